[hw/rtl/lsfe_pkg.sv]
`default_nettype none

package lsfe_pkg;

   localparam int LED_COUNT_DEFAULT        = 64;
   localparam int FRONT_RESET_ROWS_DEFAULT = 4;
   localparam int BACK_RESET_ROWS_DEFAULT  = 4;

   localparam int BYTES_PER_LED = 12;

   localparam logic [7:0] BLACK_BYTE = 8'h88;
   localparam logic [3:0] CODE_ONE_4  = 4'hE;
   localparam logic [3:0] CODE_ZERO_4 = 4'h8;
   localparam logic [2:0] CODE_ONE_3  = 3'h6;
   localparam logic [2:0] CODE_ZERO_3 = 3'h4;

   localparam logic [1:0] OP_WRITE_4 = 2'd0;
   localparam logic [1:0] OP_WRITE_3 = 2'd1;
   localparam logic [1:0] OP_EMIT    = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] led_index;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic [6:0] frame_row;
   } lsfe_req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last;
   } lsfe_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/lsfe_byte_enc.sv]
`default_nettype none

module lsfe_byte_enc (
   input  wire logic [7:0] colour,
   input  wire logic       four_bit,
   input  wire logic [1:0] byte_sel,
   output logic      [7:0] code_byte
);
   import lsfe_pkg::*;

   logic [23:0] word3;
   logic [7:0]  byte3;
   logic [7:0]  byte4;
   logic        bit_hi;
   logic        bit_lo;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         word3[3*i +: 3] = colour[i] ? CODE_ONE_3 : CODE_ZERO_3;
      end
   end

   always_comb begin
      case (byte_sel)
         2'd0:    byte3 = word3[23:16];
         2'd1:    byte3 = word3[15:8];
         default: byte3 = word3[7:0];
      endcase
   end

   // 4-bit mode: byte j carries colour bits 7-2j and 6-2j
   assign bit_hi = colour[{~byte_sel, 1'b1}];
   assign bit_lo = colour[{~byte_sel, 1'b0}];
   assign byte4  = {bit_hi ? CODE_ONE_4 : CODE_ZERO_4, bit_lo ? CODE_ONE_4 : CODE_ZERO_4};

   assign code_byte = four_bit ? byte4 : byte3;

endmodule

`default_nettype wire

[hw/rtl/led_strip_spi_frame_encoder_unit.sv]
`default_nettype none

// LED strip SPI frame encoder. Holds twelve SPI code bytes per LED in a
// byte-wide single-port store. After its beat is accepted, a pixel write
// keeps req_ready low while it writes twelve store bytes (4-bit code) or
// nine (3-bit code, bytes 9-11 untouched), one store byte per cycle through
// a shared byte encoder. An emit returns twelve beats, one per cycle when
// the sink keeps rsp_ready high; padding rows and rows past the frame read
// as zero. After reset the store is swept to 4-bit black (0x88), one byte
// per cycle over all LED_COUNT*12 bytes, and req_ready stays low until the
// sweep ends. Out-of-range writes and the unused opcode are accepted and
// leave the unit idle without effect.
module led_strip_spi_frame_encoder_unit #(
   parameter int LED_COUNT        = lsfe_pkg::LED_COUNT_DEFAULT,
   parameter int FRONT_RESET_ROWS = lsfe_pkg::FRONT_RESET_ROWS_DEFAULT,
   parameter int BACK_RESET_ROWS  = lsfe_pkg::BACK_RESET_ROWS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lsfe_pkg::lsfe_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lsfe_pkg::lsfe_rsp_type      rsp_data
);
   import lsfe_pkg::*;

   localparam int DEPTH   = LED_COUNT * BYTES_PER_LED;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_END = FRONT_RESET_ROWS + LED_COUNT;
   // back padding rows read as zero like any row past the LED rows
   localparam int FRAME_ROWS = ROW_END + BACK_RESET_ROWS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [3:0]        k_ff;
   logic [1:0]        c_ff;
   logic [1:0]        j_ff;
   logic              four_bit_ff;
   logic              zero_row_ff;
   logic [7:0]        green_ff;
   logic [7:0]        red_ff;
   logic [7:0]        blue_ff;
   logic              rsp_valid_ff;
   logic              rsp_last_ff;
   logic              rsp_zero_ff;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        mem_q_ff;

   logic              req_fire;
   logic              emit_issue;
   logic              mem_we;
   logic [7:0]        mem_wd;
   logic [7:0]        colour_sel;
   logic [7:0]        enc_byte;
   logic [1:0]        j_last;
   logic              row_in_range;
   logic              row_in_frame;
   logic              led_in_range;
   logic [6:0]        row_off;
   logic [ADDR_W-1:0] row_base;
   logic [ADDR_W-1:0] led_base;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign emit_issue = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign row_in_frame = 32'(req_data.frame_row) < 32'(FRAME_ROWS);
   assign row_in_range = row_in_frame &&
                         (32'(req_data.frame_row) >= 32'(FRONT_RESET_ROWS)) &&
                         (32'(req_data.frame_row) < 32'(ROW_END));
   assign led_in_range = 32'(req_data.led_index) < 32'(LED_COUNT);
   assign row_off      = 7'(32'(req_data.frame_row) - 32'(FRONT_RESET_ROWS));
   assign row_base     = ADDR_W'(32'(row_off) * 32'(BYTES_PER_LED));
   assign led_base     = ADDR_W'(32'(req_data.led_index) * 32'(BYTES_PER_LED));

   assign j_last = four_bit_ff ? 2'd3 : 2'd2;

   always_comb begin
      case (c_ff)
         2'd0:    colour_sel = green_ff;
         2'd1:    colour_sel = red_ff;
         default: colour_sel = blue_ff;
      endcase
   end

   lsfe_byte_enc u_enc (
      .colour    (colour_sel),
      .four_bit  (four_bit_ff),
      .byte_sel  (j_ff),
      .code_byte (enc_byte)
   );

   assign mem_we = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign mem_wd = (state_ff == ST_CLEAR) ? BLACK_BYTE : enc_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wd;
      end
      if (emit_issue) begin
         mem_q_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         k_ff         <= '0;
         c_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  green_ff <= req_data.green;
                  red_ff   <= req_data.red;
                  blue_ff  <= req_data.blue;
                  c_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  if ((req_data.opcode == OP_WRITE_4 || req_data.opcode == OP_WRITE_3)
                      && led_in_range) begin
                     four_bit_ff <= (req_data.opcode == OP_WRITE_4);
                     addr_ff     <= led_base;
                     state_ff    <= ST_WRITE;
                  end else if (req_data.opcode == OP_EMIT) begin
                     zero_row_ff <= !row_in_range;
                     addr_ff     <= row_in_range ? row_base : '0;
                     state_ff    <= ST_EMIT;
                  end
               end
            end
            ST_WRITE: begin
               addr_ff <= addr_ff + 1'b1;
               if (j_ff == j_last) begin
                  j_ff <= '0;
                  c_ff <= c_ff + 1'b1;
                  if (c_ff == 2'd2) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (emit_issue) begin
                  rsp_last_ff  <= (k_ff == 4'(BYTES_PER_LED - 1));
                  rsp_zero_ff  <= zero_row_ff;
                  k_ff         <= k_ff + 1'b1;
                  if (!zero_row_ff && k_ff != 4'(BYTES_PER_LED - 1)) begin
                     addr_ff <= addr_ff + 1'b1;
                  end
                  if (k_ff == 4'(BYTES_PER_LED - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.spi_byte = rsp_zero_ff ? 8'h00 : mem_q_ff;
   assign rsp_data.last     = rsp_last_ff;

endmodule

`default_nettype wire
